// ===== rtl/ldc_pkg.sv =====
// Shared types, codes and helpers for the list change detector.
package ldc_pkg;

   localparam int STORE_DEPTH_DEFAULT = 4096;
   localparam int VALUE_W             = 64;
   localparam int INDEX_W             = 12;
   localparam int LIMIT_W             = 13;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   // request codes
   localparam logic [1:0] REQ_COMPARE = 2'd0;
   localparam logic [1:0] REQ_STORE   = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;

   // element kinds
   localparam logic [1:0] KIND_INT    = 2'd0;
   localparam logic [1:0] KIND_FLOAT  = 2'd1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_ACCEPT,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic               emit;
      logic               wr_en;
      logic               error;
      logic               is_float;
      logic [VALUE_W-1:0] new_value;
   } result_type;

   // Truncate a signed Q31.32 pattern toward zero.
   function automatic logic [VALUE_W-1:0] trunc_q(input logic [VALUE_W-1:0] v);
      logic [31:0] hi;
      hi = v[63:32];
      if (v[63] && (v[31:0] != 32'd0)) begin
         hi = hi + 32'd1;
      end
      return {hi, 32'd0};
   endfunction

endpackage

// ===== rtl/list_change_detector_unit.sv =====
// A result beat is loaded into the result register in the lookup state that
// follows its accepted request beat, later only while that register still holds
// an unaccepted beat. No new compare or store element is taken until the last
// one is through its memory read, then compare and write back through the single
// value memory. Reset and a clear request sweep the value memory, one entry per
// cycle, over all STORE_DEPTH entries, during which no request is accepted.
module list_change_detector_unit #(
   parameter int STORE_DEPTH = ldc_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic [1:0]                          req_kind,
   input  logic signed [ldc_pkg::VALUE_W-1:0]  req_value,
   input  logic                                req_last_of_list,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ldc_pkg::INDEX_W-1:0]         rsp_index,
   output logic signed [ldc_pkg::VALUE_W-1:0]  rsp_changed_value,
   output logic                                rsp_value_kind,
   output logic                                rsp_error,
   input  logic                                csr_wr_en,
   input  logic [ldc_pkg::LIMIT_W-1:0]         csr_wr_data
);

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int PW = $clog2(STORE_DEPTH + 1);

   ldc_pkg::state_type state_ff, state_in;

   logic [ldc_pkg::LIMIT_W-1:0] limit_ff;
   logic [PW-1:0]               pos_ff, pos_in;
   logic [AW-1:0]               clr_cnt_ff, clr_cnt_in;

   logic [PW-1:0]               item_pos_ff;
   logic                        item_use_ff;
   logic                        item_store_ff;
   logic [1:0]                  item_kind_ff;
   logic [ldc_pkg::VALUE_W-1:0] item_value_ff;

   logic                        rsp_valid_ff;
   logic [ldc_pkg::INDEX_W-1:0] rsp_index_ff;
   logic [ldc_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                        rsp_kind_ff;
   logic                        rsp_error_ff;

   logic                        accept;
   logic                        is_element;
   logic                        in_use;
   logic                        clr_done;
   logic                        out_free;
   logic                        lookup_done;
   logic                        out_load;
   logic                        mem_rd_en;
   logic                        mem_wr_en;
   logic [AW-1:0]               mem_wr_addr;
   logic [ldc_pkg::VALUE_W-1:0] mem_wr_data;
   logic [ldc_pkg::VALUE_W-1:0] mem_rd_data;
   ldc_pkg::result_type         result;

   ldc_mem #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW),
      .W     (ldc_pkg::VALUE_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (pos_ff[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   ldc_eval u_eval (
      .in_use   (item_use_ff),
      .is_store (item_store_ff),
      .kind     (item_kind_ff),
      .value    (item_value_ff),
      .stored   (mem_rd_data),
      .result   (result)
   );

   always_comb begin
      accept      = req_valid && req_ready;
      is_element  = (req_type == ldc_pkg::REQ_COMPARE) || (req_type == ldc_pkg::REQ_STORE);
      in_use      = (32'(pos_ff) < 32'(limit_ff)) && (32'(pos_ff) < 32'(STORE_DEPTH));
      clr_done    = (clr_cnt_ff == AW'(STORE_DEPTH - 1));
      out_free    = !rsp_valid_ff || rsp_ready;
      lookup_done = !result.emit || out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ldc_pkg::ST_CLEAR: begin
            if (clr_done) state_in = ldc_pkg::ST_ACCEPT;
         end
         ldc_pkg::ST_ACCEPT: begin
            if (accept && (req_type == ldc_pkg::REQ_CLEAR)) begin
               state_in = ldc_pkg::ST_CLEAR;
            end else if (accept && is_element) begin
               state_in = ldc_pkg::ST_LOOKUP;
            end
         end
         ldc_pkg::ST_LOOKUP: begin
            if (lookup_done) state_in = ldc_pkg::ST_ACCEPT;
         end
         default: state_in = ldc_pkg::ST_CLEAR;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = item_pos_ff[AW-1:0];
      mem_wr_data = result.new_value;
      out_load    = 1'b0;
      clr_cnt_in  = clr_cnt_ff;
      case (state_ff)
         ldc_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = '0;
            clr_cnt_in  = clr_done ? '0 : clr_cnt_ff + AW'(1);
         end
         ldc_pkg::ST_ACCEPT: begin
            req_ready = 1'b1;
            mem_rd_en = accept && is_element && in_use;
         end
         ldc_pkg::ST_LOOKUP: begin
            mem_wr_en = lookup_done && result.wr_en;
            out_load  = result.emit && out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // running list position
   always_comb begin
      pos_in = pos_ff;
      if (accept && is_element) begin
         if (req_last_of_list) begin
            pos_in = '0;
         end else if (32'(pos_ff) != 32'(STORE_DEPTH)) begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ldc_pkg::ST_CLEAR;
         limit_ff     <= ldc_pkg::LIMIT_RESET;
         pos_ff       <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         clr_cnt_ff <= clr_cnt_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (accept && is_element) begin
         item_pos_ff   <= pos_ff;
         item_use_ff   <= in_use;
         item_store_ff <= (req_type == ldc_pkg::REQ_STORE);
         item_kind_ff  <= req_kind;
         item_value_ff <= req_value;
      end
      if (out_load) begin
         rsp_index_ff <= ldc_pkg::INDEX_W'(item_pos_ff);
         rsp_value_ff <= result.new_value;
         rsp_kind_ff  <= result.is_float;
         rsp_error_ff <= result.error;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_index         = rsp_index_ff;
   assign rsp_changed_value = rsp_value_ff;
   assign rsp_value_kind    = rsp_kind_ff;
   assign rsp_error         = rsp_error_ff;

`ifndef ASSERT_OFF
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_type == ldc_pkg::REQ_CLEAR)) |=> !req_ready)
      else $error("request taken right after a clear beat");

   a_element_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       ((req_type == ldc_pkg::REQ_COMPARE) || (req_type == ldc_pkg::REQ_STORE)))
      |=> !req_ready)
      else $error("request taken while lookup in flight");

   a_rsp_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ldc_pkg::ST_LOOKUP))
      else $error("result beat raised outside lookup");

   a_error_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> ((rsp_changed_value == '0) && !rsp_value_kind))
      else $error("error beat carries a value");
`endif

endmodule

// ===== rtl/ldc_mem.sv =====
// Single-port-write, registered-read memory holding the reference values.
module ldc_mem #(
   parameter int DEPTH = ldc_pkg::STORE_DEPTH_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int W     = ldc_pkg::VALUE_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data
);

   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ldc_eval.sv =====
// Compare datapath: truncation, change test and result selection for one element.
module ldc_eval (
   input  logic                         in_use,
   input  logic                         is_store,
   input  logic [1:0]                   kind,
   input  logic [ldc_pkg::VALUE_W-1:0]  value,
   input  logic [ldc_pkg::VALUE_W-1:0]  stored,
   output ldc_pkg::result_type          result
);

   logic                        is_int;
   logic                        is_symbol;
   logic [ldc_pkg::VALUE_W-1:0] nv;
   logic [ldc_pkg::VALUE_W-1:0] ref_value;
   logic                        differs;

   always_comb begin
      is_int    = (kind == ldc_pkg::KIND_INT);
      is_symbol = (kind != ldc_pkg::KIND_INT) && (kind != ldc_pkg::KIND_FLOAT);
      nv        = is_int ? ldc_pkg::trunc_q(value) : value;
      ref_value = is_int ? ldc_pkg::trunc_q(stored) : stored;
      differs   = (nv != ref_value);

      result = '0;
      if (in_use) begin
         if (is_symbol) begin
            // reject: report position only, store untouched
            result.emit  = 1'b1;
            result.error = 1'b1;
         end else begin
            result.new_value = nv;
            result.is_float  = kind[0];
            result.wr_en     = is_store || differs;
            result.emit      = !is_store && differs;
         end
      end
   end

endmodule

// ===== test/list_change_detector_unit_test.sv =====
// Self-checking testbench for the list change detector: directed and random lists against a predictor.
module list_change_detector_unit_test;

   localparam int STORE_DEPTH    = ldc_pkg::STORE_DEPTH_DEFAULT;
   localparam int VALUE_W        = ldc_pkg::VALUE_W;
   localparam int INDEX_W        = ldc_pkg::INDEX_W;
   localparam int LIMIT_W        = ldc_pkg::LIMIT_W;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PRINT_LIMIT    = 40;

   // codes the package leaves unnamed
   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam logic [1:0] KIND_SYMBOL = 2'd2;
   localparam logic [1:0] KIND_OTHER  = 2'd3;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      logic               float_kind;
      logic               error;
   } change_report_type;

   class change_tracker;
      bit [VALUE_W-1:0]  entry_value [STORE_DEPTH];
      bit                entry_float [STORE_DEPTH];
      int unsigned       position;
      int unsigned       list_limit;
      change_report_type expected [$];
      int unsigned       mismatches;

      function new();
         wipe();
         position   = 0;
         list_limit = STORE_DEPTH;
         mismatches = 0;
      endfunction

      function void wipe();
         foreach (entry_value[i]) begin
            entry_value[i] = '0;
            entry_float[i] = 1'b0;
         end
      endfunction

      // Q31.32 toward zero, by signed division
      function bit [VALUE_W-1:0] toward_zero(bit [VALUE_W-1:0] q);
         longint whole;
         whole = $signed(q) / 64'sd4294967296;
         return whole << 32;
      endfunction

      function int unsigned pending();
         return expected.size();
      endfunction

      function void note_element(logic [1:0] rtype, logic [1:0] rkind,
                                 logic [VALUE_W-1:0] rvalue, logic rlast);
         int unsigned       in_use;
         bit [VALUE_W-1:0]  fresh;
         bit [VALUE_W-1:0]  held;
         change_report_type beat;
         if (rtype == ldc_pkg::REQ_CLEAR) begin
            wipe();
            return;
         end
         if (rtype == REQ_UNUSED) return;
         in_use = (list_limit < STORE_DEPTH) ? list_limit : STORE_DEPTH;
         if (position < in_use) begin
            beat.index = INDEX_W'(position);
            if (rkind == KIND_SYMBOL || rkind == KIND_OTHER) begin
               beat.value      = '0;
               beat.float_kind = 1'b0;
               beat.error      = 1'b1;
               expected.push_back(beat);
            end else begin
               fresh = (rkind == ldc_pkg::KIND_INT) ? toward_zero(rvalue) : rvalue;
               if (rtype == ldc_pkg::REQ_STORE) begin
                  entry_value[position] = fresh;
                  entry_float[position] = (rkind == ldc_pkg::KIND_FLOAT);
               end else begin
                  held = (rkind == ldc_pkg::KIND_INT) ? toward_zero(entry_value[position])
                                                      : entry_value[position];
                  if (fresh != held) begin
                     entry_value[position] = fresh;
                     entry_float[position] = (rkind == ldc_pkg::KIND_FLOAT);
                     beat.value      = fresh;
                     beat.float_kind = (rkind == ldc_pkg::KIND_FLOAT);
                     beat.error      = 1'b0;
                     expected.push_back(beat);
                  end
               end
            end
         end
         if (rlast) position = 0;
         else if (position < STORE_DEPTH) position++;
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= PRINT_LIMIT) $display("MISMATCH: %s", what);
      endtask

      task check_report(logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val,
                        logic kind, logic err);
         change_report_type want;
         if (expected.size() == 0) begin
            report($sformatf("result beat with none expected, index %0d", idx));
            return;
         end
         want = expected.pop_front();
         if (idx !== want.index || val !== want.value ||
             kind !== want.float_kind || err !== want.error)
            report($sformatf({"got idx %0d val %h kind %0d err %0d, ",
                              "want idx %0d val %h kind %0d err %0d"},
                             idx, val, kind, err,
                             want.index, want.value, want.float_kind, want.error));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_type = ldc_pkg::REQ_COMPARE;
   logic [1:0]          req_kind = ldc_pkg::KIND_INT;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                req_last_of_list = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [INDEX_W-1:0]  rsp_index;
   logic [VALUE_W-1:0]  rsp_changed_value;
   logic                rsp_value_kind;
   logic                rsp_error;
   logic                csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]  csr_wr_data = ldc_pkg::LIMIT_RESET;

   change_tracker tracker = new();
   bit          sender_gaps = 1'b1;
   bit          receiver_stalls = 1'b1;
   bit          hold_output = 1'b0;
   int unsigned accepted_items = 0;
   int unsigned idle_cycles = 0;

   list_change_detector_unit #(.STORE_DEPTH(STORE_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_kind(req_kind),
      .req_value(req_value),
      .req_last_of_list(req_last_of_list),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_index(rsp_index),
      .rsp_changed_value(rsp_changed_value),
      .rsp_value_kind(rsp_value_kind),
      .rsp_error(rsp_error),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         tracker.check_report(rsp_index, rsp_changed_value, rsp_value_kind, rsp_error);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_output) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic send_element(logic [1:0] rtype, logic [1:0] rkind,
                               logic [VALUE_W-1:0] rvalue, logic rlast);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= rtype;
      req_kind         <= rkind;
      req_value        <= rvalue;
      req_last_of_list <= rlast;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.note_element(rtype, rkind, rvalue, rlast);
      accepted_items++;
   endtask

   // drop valid and wait until every expected beat is back and the block is idle
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] limit);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.list_limit = limit;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [31:0] whole;
      whole = $urandom_range(0, 16) - 8;
      case ($urandom_range(0, 6))
         0: return {$urandom, $urandom};
         1: return {whole, $urandom};
         2: return {whole, 32'd0};
         3: return 64'h7FFF_FFFF_FFFF_FFFF;
         4: return 64'h8000_0000_0000_0000;
         5: return {32'hFFFF_FFFF, $urandom};   // small negative fraction
         default: return '0;
      endcase
   endfunction

   function automatic logic [1:0] pick_kind();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0) return KIND_SYMBOL;
      if (r == 1) return KIND_OTHER;
      return r[0] ? ldc_pkg::KIND_FLOAT : ldc_pkg::KIND_INT;
   endfunction

   task automatic directed_checks();
      // first list: fill the reference entries
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_INT,   64'h0, 1'b0);
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_INT,   64'h0000_0007_8000_0000, 1'b0);
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_INT,   64'hFFFF_FFF8_8000_0000, 1'b0);
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_FLOAT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_FLOAT, 64'h8000_0000_0000_0000, 1'b0);
      send_element(ldc_pkg::REQ_STORE,   ldc_pkg::KIND_FLOAT, 64'h0000_0003_C000_0000, 1'b0);
      send_element(ldc_pkg::REQ_COMPARE, KIND_SYMBOL,         64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_element(ldc_pkg::REQ_STORE,   KIND_OTHER,          64'h1234_5678_9ABC_DEF0, 1'b1);
      // second list: truncation, unknown request, clear in the middle
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_INT,   64'h0, 1'b0);
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_INT,   64'h0000_0007_4000_0000, 1'b0);
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_FLOAT, 64'hFFFF_FFF9_0000_0000, 1'b0);
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_INT,   64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      send_element(REQ_UNUSED,           ldc_pkg::KIND_FLOAT, 64'h5555_AAAA_5555_AAAA, 1'b1);
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_INT,   64'hFFFF_FFFE_8000_0000, 1'b0);
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_INT,   64'h0000_0003_0000_0000, 1'b0);
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_FLOAT, 64'h0000_0000_8000_0000, 1'b0);
      send_element(ldc_pkg::REQ_CLEAR,   KIND_OTHER,          64'hAAAA_5555_AAAA_5555, 1'b1);
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_INT,   64'h0, 1'b1);
      // one position in use: later elements drop silently
      write_limit(LIMIT_W'(1));
      send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_FLOAT, 64'h0000_0001_0000_0000, 1'b0);
      send_element(ldc_pkg::REQ_COMPARE, KIND_SYMBOL,         64'h0, 1'b0);
      send_element(ldc_pkg::REQ_STORE,   ldc_pkg::KIND_FLOAT, 64'h0000_0002_0000_0000, 1'b1);
   endtask

   task automatic run_phase(int unsigned count);
      int unsigned      target;
      int unsigned      cap;
      int unsigned      len;
      int unsigned      r;
      logic [VALUE_W-1:0] vals [24];
      logic [1:0]       kinds [24];
      target = accepted_items + count;
      while (accepted_items < target) begin
         cap = tracker.list_limit + 2;
         if (cap > 24) cap = 24;
         len = $urandom_range(1, cap);
         if ($urandom_range(0, 59) == 0) begin
            send_element(ldc_pkg::REQ_CLEAR, 2'($urandom), pick_value(), 1'($urandom));
         end else if ($urandom_range(0, 4) == 0) begin
            // noise: any request but clear, random list breaks
            for (int i = 0; i < len; i++) begin
               r = $urandom_range(0, 2);
               send_element((r == 2) ? REQ_UNUSED : 2'(r), 2'($urandom), pick_value(),
                            (i == len - 1) || ($urandom_range(0, 3) == 0));
            end
         end else begin
            for (int i = 0; i < len; i++) begin
               vals[i]  = pick_value();
               kinds[i] = pick_kind();
            end
            if ($urandom_range(0, 1) == 1) begin
               for (int i = 0; i < len; i++)
                  send_element(ldc_pkg::REQ_STORE, kinds[i], vals[i], i == len - 1);
            end
            repeat ($urandom_range(1, 3)) begin
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(0, 3) == 0) begin
                     case ($urandom_range(0, 2))
                        0: vals[i] = pick_value();
                        1: vals[i][31:0] = $urandom;
                        default: kinds[i] = (kinds[i] < KIND_SYMBOL) ? (kinds[i] ^ 2'd1)
                                                                     : pick_kind();
                     endcase
                  end
                  send_element(ldc_pkg::REQ_COMPARE, kinds[i], vals[i], i == len - 1);
               end
            end
         end
      end
   endtask

   initial begin
      logic [LIMIT_W-1:0] phase_limits [6];
      phase_limits = '{ldc_pkg::LIMIT_RESET, 13'd2, 13'd9, 13'd1, 13'd33, 13'd128};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      directed_checks();
      foreach (phase_limits[p]) begin
         write_limit(phase_limits[p]);
         run_phase(250);
      end
      write_limit(ldc_pkg::LIMIT_RESET);
      // long hold on the result side while requests keep coming
      hold_output = 1'b1;
      repeat (48) send_element(ldc_pkg::REQ_COMPARE, ldc_pkg::KIND_FLOAT,
                               {$urandom, $urandom}, $urandom_range(0, 15) == 0);
      settle();
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      run_phase(300);
      settle();
      if (tracker.pending() != 0)
         tracker.report($sformatf("%0d expected beats never arrived", tracker.pending()));
      if (tracker.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ldc_pkg.sv
rtl/ldc_mem.sv
rtl/ldc_eval.sv
rtl/list_change_detector_unit.sv
test/list_change_detector_unit_test.sv
